// ===== rtl/fixed_block_range_allocator_core_macros.svh =====
// assertion macros for the fixed block range allocator
// used by the top level, which supplies clk and rst_n
`ifndef FIXED_BLOCK_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_RANGE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FBRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbra_pkg.sv =====
// shared types and codes for the fixed block range allocator
// no dependencies
package fbra_pkg;

  localparam int DIV_DW = 16;  // divider dividend width
  localparam int DIV_VW = 8;   // divider divisor width
  localparam int CW     = 11;  // cell / range field width

  localparam logic [2:0] FN_INIT   = 3'd0;
  localparam logic [2:0] FN_ALLOC  = 3'd1;
  localparam logic [2:0] FN_LOOKUP = 3'd2;
  localparam logic [2:0] FN_HEAD   = 3'd3;
  localparam logic [2:0] FN_LINK   = 3'd4;

  localparam logic [2:0] RS_ALLOC   = 3'd0;
  localparam logic [2:0] RS_FULL    = 3'd1;
  localparam logic [2:0] RS_OCC     = 3'd2;
  localparam logic [2:0] RS_FREE    = 3'd3;
  localparam logic [2:0] RS_WRITTEN = 3'd4;
  localparam logic [2:0] RS_LIMIT   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_INIT,
    ST_INIT_FIN,
    ST_DIV_BLK,
    ST_WALK_CHK,
    ST_WALK_LD
  } fbra_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fbra_div_stat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  block_cell;
    logic [13:0] page_bytes;
    logic        young_mark;
  } fbra_res_t;

  function automatic fbra_res_t make_res(logic [2:0] st, logic [9:0] blk,
                                         logic [13:0] bytes, logic young);
    fbra_res_t r;
    r.status     = st;
    r.block_cell = blk;
    r.page_bytes = bytes;
    r.young_mark = young;
    return r;
  endfunction

endpackage

// ===== rtl/fbra_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on fbra_pkg
module fbra_div import fbra_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output fbra_div_stat_t    stat,
  output logic [DIV_VW-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_DW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_VW:0]   trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_DW-1]};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_VW'(trial - {1'b0, dvs_r}) : trial[DIV_VW-1:0];
      quo_nxt = {quo_r[DIV_DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/fixed_block_range_allocator_core.sv =====
// Fixed block range allocator: one page of CELL_COUNT cells carved into blocks of
// block_size cells, free space kept as a list of ranges whose links live in a
// two-port link memory at each range's last cell. One request is worked at a
// time; a result waits in an output register while the next request is taken.
// Writes and plain allocations finish in the exec state; an allocation that ends a
// range adds one link memory read, then a clearing write. Init and lookup each run
// the divider once, and a lookup reads the link memory once for each range followed.
module fixed_block_range_allocator_core import fbra_pkg::*; #(
  parameter int CELL_COUNT = 1024,
  parameter int CELL_BYTES = 8,
  parameter int MAX_BLOCK  = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_byte_offset,
  input  logic [9:0]  in_link_cell,
  input  logic [10:0] in_range_first,
  input  logic [10:0] in_range_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_block_cell,
  output logic [13:0] out_page_bytes,
  output logic        out_young_mark
);

  localparam int AW     = $clog2(CELL_COUNT);
  localparam int STEP_W = $clog2(CELL_COUNT + 1);
  localparam int LIM_W  = CW + $clog2(CELL_BYTES + 1);
  localparam int CMP_W  = (LIM_W > 16) ? LIM_W : 16;
  localparam int LW     = 2 * CW;
  // byte offset to cell by reciprocal multiply, exact for every 16-bit offset
  localparam int RCP_K  = 16 + $clog2(CELL_BYTES);
  localparam int RCP_W  = 18;
  localparam int RCP_PW = 16 + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_K) + 64'(CELL_BYTES) - 64'd1) / 64'(CELL_BYTES));

  fbra_state_t state_r, state_nxt;

  logic [7:0]        block_size_r;
  logic [CW-1:0]     head_first_r, head_first_nxt;
  logic [CW-1:0]     head_last_r, head_last_nxt;
  logic [CW-1:0]     page_end_r, page_end_nxt;
  logic              young_r, young_nxt;
  logic              out_valid_r, out_valid_nxt;
  fbra_res_t         out_res_r, out_res_nxt;

  // latched request
  logic [2:0]        func_r;
  logic [15:0]       off_r;
  logic [9:0]        lcell_r;
  logic [CW-1:0]     rfirst_r;
  logic [CW-1:0]     rlast_r;

  // walk context
  logic [CW-1:0]     cell_r, cell_nxt;
  logic [CW-1:0]     start_r, start_nxt;
  logic [CW-1:0]     rf_r, rf_nxt;
  logic [CW-1:0]     rl_r, rl_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  // link memory
  logic [LW-1:0]     link_mem [CELL_COUNT];
  logic [LW-1:0]     rd_data_r;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LW-1:0]     mem_wdata;

  // divider
  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  fbra_div_stat_t    div_stat;
  logic [DIV_VW-1:0] div_rem;

  logic [7:0]        bs;
  logic [LIM_W-1:0]  limit;
  logic [13:0]       page_bytes;
  logic [CW:0]       bump;
  logic [RCP_PW-1:0] rcp_prod;
  logic [DIV_DW-1:0] off_cell;
  logic              out_free;
  logic              accept;

  fbra_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // effective block size: zero counts as one, clamp at MAX_BLOCK
  always_comb begin
    if (block_size_r == 8'd0) begin
      bs = 8'd1;
    end else if (32'(block_size_r) > MAX_BLOCK) begin
      bs = 8'(MAX_BLOCK);
    end else begin
      bs = block_size_r;
    end
  end

  assign limit      = LIM_W'(page_end_r) * LIM_W'(CELL_BYTES);
  assign page_bytes = (limit > LIM_W'(14'h3fff)) ? 14'h3fff : limit[13:0];
  assign bump       = {1'b0, head_first_r} + (CW + 1)'(bs);
  assign rcp_prod   = RCP_PW'(off_r) * RCP_PW'(RCP_M);
  assign off_cell   = DIV_DW'(rcp_prod >> RCP_K);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    head_first_nxt = head_first_r;
    head_last_nxt  = head_last_r;
    page_end_nxt   = page_end_r;
    young_nxt      = young_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    cell_nxt       = cell_r;
    start_nxt      = start_r;
    rf_nxt         = rf_r;
    rl_nxt         = rl_r;
    steps_nxt      = steps_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = head_first_r[AW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = lcell_r[AW-1:0];
    mem_wdata      = {rlast_r, rfirst_r};
    div_start      = 1'b0;
    div_dividend   = off_cell;
    div_divisor    = bs;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (func_r)
          FN_INIT: begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(CELL_COUNT);
            div_divisor  = bs;
            state_nxt    = ST_DIV_INIT;
          end
          FN_ALLOC: begin
            if (head_first_r >= page_end_r) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = make_res(RS_FULL, 10'd0, page_bytes, young_r);
                state_nxt     = ST_IDLE;
              end
            end else if (head_first_r < head_last_r) begin
              if (out_free) begin
                head_first_nxt = bump[CW] ? {CW{1'b1}} : bump[CW-1:0];
                young_nxt      = 1'b1;
                out_valid_nxt  = 1'b1;
                out_res_nxt    = make_res(RS_ALLOC, head_first_r[9:0], 14'd0, 1'b1);
                state_nxt      = ST_IDLE;
              end
            end else begin
              // range end: fetch the link, finish in the alloc load state
              mem_rd_en   = 1'b1;
              mem_rd_addr = head_first_r[AW-1:0];
              state_nxt   = ST_WALK_LD;
            end
          end
          FN_LOOKUP: begin
            if (CMP_W'(off_r) >= CMP_W'(limit)) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = make_res(RS_FREE, 10'd0, 14'd0, young_r);
                state_nxt     = ST_IDLE;
              end
            end else begin
              // cell of the offset, then its remainder within the block
              cell_nxt  = off_cell[CW-1:0];
              div_start = 1'b1;
              state_nxt = ST_DIV_BLK;
            end
          end
          FN_HEAD: begin
            if (out_free) begin
              head_first_nxt = rfirst_r;
              head_last_nxt  = rlast_r;
              out_valid_nxt  = 1'b1;
              out_res_nxt    = make_res(RS_WRITTEN, 10'd0, 14'd0, young_r);
              state_nxt      = ST_IDLE;
            end
          end
          FN_LINK: begin
            if (out_free) begin
              mem_we        = (32'(lcell_r) < CELL_COUNT);
              out_valid_nxt = 1'b1;
              out_res_nxt   = make_res(RS_WRITTEN, 10'd0, 14'd0, young_r);
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = make_res(RS_WRITTEN, 10'd0, 14'd0, young_r);
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end

      ST_DIV_INIT: begin
        if (div_stat.done) begin
          state_nxt = ST_INIT_FIN;
        end
      end

      ST_INIT_FIN: begin
        if (out_free) begin
          page_end_nxt   = CW'(CELL_COUNT) - CW'(div_rem);
          head_last_nxt  = CW'(CELL_COUNT) - CW'(div_rem);
          head_first_nxt = '0;
          young_nxt      = 1'b0;
          out_valid_nxt  = 1'b1;
          out_res_nxt    = make_res(RS_WRITTEN, 10'd0, 14'd0, 1'b0);
          state_nxt      = ST_IDLE;
        end
      end

      ST_DIV_BLK: begin
        if (div_stat.done) begin
          start_nxt = cell_r - CW'(div_rem);
          rf_nxt    = head_first_r;
          rl_nxt    = head_last_r;
          steps_nxt = '0;
          state_nxt = ST_WALK_CHK;
        end
      end

      ST_WALK_CHK: begin
        if (start_r < rf_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = make_res(RS_OCC, start_r[9:0], 14'd0, young_r);
            state_nxt     = ST_IDLE;
          end
        end else if (start_r <= rl_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = make_res(RS_FREE, start_r[9:0], 14'd0, young_r);
            state_nxt     = ST_IDLE;
          end
        end else if (rl_r >= page_end_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = make_res(RS_OCC, start_r[9:0], 14'd0, young_r);
            state_nxt     = ST_IDLE;
          end
        end else if (steps_r == STEP_W'(CELL_COUNT)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = make_res(RS_LIMIT, start_r[9:0], 14'd0, young_r);
            state_nxt     = ST_IDLE;
          end
        end else begin
          steps_nxt   = steps_r + 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = rl_r[AW-1:0];
          state_nxt   = ST_WALK_LD;
        end
      end

      ST_WALK_LD: begin
        if (func_r == FN_ALLOC) begin
          // take the range end cell, load the next range, clear the link
          if (out_free) begin
            head_first_nxt = rd_data_r[CW-1:0];
            head_last_nxt  = rd_data_r[LW-1:CW];
            mem_we         = 1'b1;
            mem_waddr      = head_first_r[AW-1:0];
            mem_wdata      = '0;
            young_nxt      = 1'b1;
            out_valid_nxt  = 1'b1;
            out_res_nxt    = make_res(RS_ALLOC, head_first_r[9:0], 14'd0, 1'b1);
            state_nxt      = ST_IDLE;
          end
        end else begin
          rf_nxt    = rd_data_r[CW-1:0];
          rl_nxt    = rd_data_r[LW-1:CW];
          state_nxt = ST_WALK_CHK;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      block_size_r <= 8'd1;
      head_first_r <= '0;
      head_last_r  <= '0;
      page_end_r   <= '0;
      young_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_first_r <= head_first_nxt;
      head_last_r  <= head_last_nxt;
      page_end_r   <= page_end_nxt;
      young_r      <= young_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        block_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    cell_r    <= cell_nxt;
    start_r   <= start_nxt;
    rf_r      <= rf_nxt;
    rl_r      <= rl_nxt;
    steps_r   <= steps_nxt;
    if (accept) begin
      func_r   <= in_func;
      off_r    <= in_byte_offset;
      lcell_r  <= in_link_cell;
      rfirst_r <= in_range_first;
      rlast_r  <= in_range_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_data_r <= link_mem[mem_rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_block_cell = out_res_r.block_cell;
  assign out_page_bytes = out_res_r.page_bytes;
  assign out_young_mark = out_res_r.young_mark;

`include "fixed_block_range_allocator_core_macros.svh"

  `FBRA_ASSERT_NXT(a_accept_exec, accept, state_r == ST_EXEC, "request not taken into exec")
  `FBRA_ASSERT_IMP(a_div_alive, state_r == ST_DIV_INIT || state_r == ST_DIV_BLK,
    div_stat.busy || div_stat.done, "waiting on an idle divider")
  `FBRA_ASSERT_IMP(a_steps_bound, state_r == ST_WALK_CHK,
    32'(steps_r) <= CELL_COUNT, "walk step count past limit")
  `FBRA_ASSERT_IMP(a_page_end, 1'b1, 32'(page_end_r) <= CELL_COUNT,
    "page end beyond cell count")

endmodule

// ===== tb/sv/fixed_block_range_allocator_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for fixed_block_range_allocator_core: predicts each reply
// from its own copy of the page state and checks the replies in order
// depends on fbra_pkg and the core rtl
module fixed_block_range_allocator_core_test;
  import fbra_pkg::*;

  localparam int CELLS       = 1024;
  localparam int CELL_SZ     = 8;
  localparam int BLOCK_CAP   = 128;
  localparam int RANDOM_REQS = 700;
  localparam int CYCLE_CAP   = 2000000;
  localparam logic [2:0] FN_SPARE_MIN = FN_LINK + 3'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] byte_offset;
    logic [9:0]  link_cell;
    logic [10:0] range_first;
    logic [10:0] range_last;
  } page_req_t;

  localparam int REQ_BITS = $bits(page_req_t);

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [15:0] in_byte_offset;
  logic [9:0]  in_link_cell;
  logic [10:0] in_range_first;
  logic [10:0] in_range_last;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [9:0]  out_block_cell;
  logic [13:0] out_page_bytes;
  logic        out_young_mark;

  // predicted page state
  logic [7:0]  bsize_reg = 8'd1;
  int          hd_first  = 0;
  int          hd_last   = 0;
  int          pg_end    = 0;
  logic        young     = 1'b0;
  logic [21:0] link_mem [CELLS];
  bit          link_set [CELLS];

  fbra_res_t   due_replies[$];
  fbra_res_t   want;
  fbra_res_t   seen;
  int          fails       = 0;
  int          replies_got = 0;
  int          reqs_sent   = 0;
  int          full_hits   = 0;
  int          walk_limits = 0;
  int          cycles      = 0;
  bit          quiet       = 1'b0;

  fixed_block_range_allocator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_byte_offset (in_byte_offset),
    .in_link_cell   (in_link_cell),
    .in_range_first (in_range_first),
    .in_range_last  (in_range_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_block_cell (out_block_cell),
    .out_page_bytes (out_page_bytes),
    .out_young_mark (out_young_mark)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int blk_cells();
    if (bsize_reg == 8'd0) return 1;
    if (bsize_reg > BLOCK_CAP) return BLOCK_CAP;
    return bsize_reg;
  endfunction

  // follows the free ranges from the head; returns the first never-written link
  // cell the walk would read, or -1 when every read is defined
  function automatic int walk_free_list(input int start, output logic [2:0] st);
    int rf = hd_first;
    int rl = hd_last;
    int steps = 0;
    int miss = -1;
    bit done = 1'b0;
    st = RS_LIMIT;
    while (!done) begin
      if (start < rf) begin
        st = RS_OCC;
        done = 1'b1;
      end else if (start <= rl) begin
        st = RS_FREE;
        done = 1'b1;
      end else if (rl >= pg_end) begin
        st = RS_OCC;
        done = 1'b1;
      end else if (steps >= CELLS) begin
        st = RS_LIMIT;
        done = 1'b1;
      end else if (!link_set[rl]) begin
        miss = rl;
        done = 1'b1;
      end else begin
        steps++;
        rf = link_mem[rl][10:0];
        rl = link_mem[rl][21:11];
      end
    end
    return miss;
  endfunction

  function automatic int lookup_start(input logic [15:0] off);
    int o = off;
    return ((o / CELL_SZ) / blk_cells()) * blk_cells();
  endfunction

  function automatic int missing_link(input page_req_t r);
    logic [2:0] st;
    int o = r.byte_offset;
    if (r.func == FN_ALLOC && hd_first < pg_end && hd_first >= hd_last && !link_set[hd_first])
      return hd_first;
    if (r.func == FN_LOOKUP && o < pg_end * CELL_SZ)
      return walk_free_list(lookup_start(r.byte_offset), st);
    return -1;
  endfunction

  // a link that only points further up the page, or ends the list
  function automatic logic [21:0] forward_link(input int lc);
    int nl, nf;
    nl = $urandom_range(2047, lc + 1);
    nf = $urandom_range(nl, 0);
    return {11'(nl), 11'(nf)};
  endfunction

  function automatic page_req_t mk_req(input logic [2:0] func, input logic [15:0] off,
                                       input logic [9:0] lcell, input logic [10:0] rf,
                                       input logic [10:0] rl);
    page_req_t r;
    r.func        = func;
    r.byte_offset = off;
    r.link_cell   = lcell;
    r.range_first = rf;
    r.range_last  = rl;
    return r;
  endfunction

  task automatic step_page(input page_req_t r);
    fbra_res_t  res;
    logic [2:0] st;
    int bs, nx, start, o;
    bs = blk_cells();
    o = r.byte_offset;
    res = '0;
    res.status = RS_WRITTEN;
    case (r.func)
      FN_INIT: begin
        pg_end   = (CELLS / bs) * bs;
        hd_first = 0;
        hd_last  = pg_end;
        young    = 1'b0;
      end
      FN_ALLOC: begin
        nx = hd_first;
        if (nx >= pg_end) begin
          res.status     = RS_FULL;
          res.page_bytes = (pg_end * CELL_SZ > 16383) ? 14'h3fff : 14'(pg_end * CELL_SZ);
          full_hits++;
        end else begin
          if (nx < hd_last) begin
            hd_first = (nx + bs > 2047) ? 2047 : nx + bs;
          end else begin
            // range used up: hand out its last cell and move to the linked range
            hd_first     = link_mem[nx][10:0];
            hd_last      = link_mem[nx][21:11];
            link_mem[nx] = '0;
          end
          young          = 1'b1;
          res.status     = RS_ALLOC;
          res.block_cell = 10'(nx);
        end
      end
      FN_LOOKUP: begin
        if (o >= pg_end * CELL_SZ) begin
          res.status = RS_FREE;
        end else begin
          start = lookup_start(r.byte_offset);
          void'(walk_free_list(start, st));
          res.status     = st;
          res.block_cell = 10'(start);
          if (st == RS_LIMIT) walk_limits++;
        end
      end
      FN_HEAD: begin
        hd_first = r.range_first;
        hd_last  = r.range_last;
      end
      FN_LINK: begin
        link_mem[r.link_cell] = {r.range_last, r.range_first};
        link_set[r.link_cell] = 1'b1;
      end
      default: ;
    endcase
    res.young_mark = young;
    due_replies.insert(due_replies.size(), res);
  endtask

  task automatic offer(input page_req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= r.func;
    in_byte_offset <= r.byte_offset;
    in_link_cell   <= r.link_cell;
    in_range_first <= r.range_first;
    in_range_last  <= r.range_last;
    do @(posedge clk); while (!in_ready);
    step_page(r);
    reqs_sent++;
  endtask

  // a request that would read a never-written link gets that link written first
  task automatic send_req(input page_req_t r);
    int lc;
    logic [21:0] lk;
    lc = missing_link(r);
    while (lc >= 0) begin
      lk = forward_link(lc);
      offer(mk_req(FN_LINK, 16'($urandom), 10'(lc), lk[10:0], lk[21:11]));
      lc = missing_link(r);
    end
    offer(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bsize_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      replies_got++;
      seen.status     = out_status;
      seen.block_cell = out_block_cell;
      seen.page_bytes = out_page_bytes;
      seen.young_mark = out_young_mark;
      if (due_replies.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("reply with no request outstanding: status %0d cell %0d bytes %0d",
                   seen.status, seen.block_cell, seen.page_bytes);
      end else begin
        want = due_replies.pop_front();
        if (seen.status !== want.status || seen.block_cell !== want.block_cell ||
            seen.page_bytes !== want.page_bytes || seen.young_mark !== want.young_mark) begin
          fails++;
          if (fails <= 10)
            $display("reply %0d mismatch (exp/got): status %0d/%0d cell %0d/%0d",
                     replies_got, want.status, seen.status, want.block_cell,
                     seen.block_cell, " bytes %0d/%0d young %0b/%0b",
                     want.page_bytes, seen.page_bytes, want.young_mark, seen.young_mark);
        end
      end
    end
  end

  initial begin : ready_driver
    int hold;
    out_ready = 1'b0;
    forever begin
      hold = draw_gap();
      if (hold == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // before init the page is empty: nothing to allocate, every offset is outside
  task automatic test_empty_page();
    send_req(mk_req(FN_ALLOC, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_LOOKUP, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_LOOKUP, 16'hffff, 10'h3ff, 11'h7ff, 11'h7ff));
    send_req(mk_req(FN_HEAD, 16'h0000, 10'd0, 11'h7ff, 11'd0));
    send_req(mk_req(FN_LINK, 16'h0000, 10'h3ff, 11'h7ff, 11'd0));
    for (int f = FN_SPARE_MIN; f <= 7; f++)
      send_req(mk_req(3'(f), 16'($urandom), 10'($urandom), 11'($urandom), 11'($urandom)));
  endtask

  // zero counts as one cell, oversize saturates, odd sizes leave a page tail
  task automatic test_block_sizes();
    logic [7:0] sizes [3] = '{8'd0, 8'd255, 8'd3};
    int lim;
    foreach (sizes[i]) begin
      write_block_size(sizes[i]);
      send_req(mk_req(FN_INIT, 16'h0000, 10'd0, 11'd0, 11'd0));
      send_req(mk_req(FN_ALLOC, 16'h0000, 10'd0, 11'd0, 11'd0));
      lim = pg_end * CELL_SZ;
      send_req(mk_req(FN_LOOKUP, 16'(lim - 1), 10'd0, 11'd0, 11'd0));
      send_req(mk_req(FN_LOOKUP, 16'(lim), 10'd0, 11'd0, 11'd0));
    end
  endtask

  // head at page end reports full even with a larger range end
  task automatic test_page_full();
    write_block_size(8'd128);
    send_req(mk_req(FN_INIT, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_HEAD, 16'h0000, 10'd0, 11'd1024, 11'h7ff));
    send_req(mk_req(FN_ALLOC, 16'h0000, 10'd0, 11'd0, 11'd0));
  endtask

  task automatic test_range_end();
    send_req(mk_req(FN_LINK, 16'h0000, 10'd0, 11'd256, 11'h7ff));
    send_req(mk_req(FN_HEAD, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_ALLOC, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_ALLOC, 16'h0000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_LOOKUP, 16'd8, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_LOOKUP, 16'd4000, 10'd0, 11'd0, 11'd0));
  endtask

  // a link that points back at its own range keeps the walk going until the step limit
  task automatic test_walk_limit();
    send_req(mk_req(FN_LINK, 16'h0000, 10'd10, 11'd0, 11'd10));
    send_req(mk_req(FN_HEAD, 16'h0000, 10'd0, 11'd0, 11'd10));
    send_req(mk_req(FN_LOOKUP, 16'd4000, 10'd0, 11'd0, 11'd0));
    send_req(mk_req(FN_LINK, 16'h0000, 10'd10, 11'd0, 11'h7ff));
  endtask

  // free lists carved from random block runs, then mostly allocations and
  // lookups with some list rewrites and stray requests mixed in
  task automatic test_random_free_lists();
    page_req_t r;
    int firsts[$];
    int lasts[$];
    int base, pick, bs, pe, nb, pos, f, l, n, kind;
    logic [21:0] lk;
    base = reqs_sent;
    while (reqs_sent - base < RANDOM_REQS) begin
      pick = $urandom_range(9, 0);
      quiet = ($urandom_range(7, 0) == 0);
      if (pick < 2) write_block_size(8'($urandom_range(7, 1)));
      else if (pick < 8) write_block_size(8'($urandom_range(128, 8)));
      else write_block_size(8'($urandom_range(255, 0)));
      send_req(mk_req(FN_INIT, 16'($urandom), 10'($urandom), 11'($urandom), 11'($urandom)));
      bs = blk_cells();
      pe = pg_end;
      nb = pe / bs;
      firsts.delete();
      lasts.delete();
      pos = $urandom_range((nb * 3) / 4, 0);
      while (pos < nb && firsts.size() < 6) begin
        f = pos;
        l = f + $urandom_range(4, 0);
        if (l >= nb) l = nb - 1;
        firsts.insert(firsts.size(), f * bs);
        lasts.insert(lasts.size(), l * bs);
        pos = l + 1 + $urandom_range(5, 0);
      end
      // list end either in the last range itself or in a link at its last cell
      if ($urandom_range(1, 0) == 1) begin
        lasts[lasts.size() - 1] = $urandom_range(2047, pe);
      end else begin
        l = lasts[lasts.size() - 1];
        send_req(mk_req(FN_LINK, 16'($urandom), 10'(l), 11'($urandom),
                        11'($urandom_range(2047, pe))));
      end
      for (int i = 0; i + 1 < firsts.size(); i++)
        send_req(mk_req(FN_LINK, 16'($urandom), 10'(lasts[i]), 11'(firsts[i + 1]),
                        11'(lasts[i + 1])));
      send_req(mk_req(FN_HEAD, 16'($urandom), 10'($urandom), 11'(firsts[0]), 11'(lasts[0])));
      n = $urandom_range(45, 15);
      repeat (n) begin
        r = REQ_BITS'({$urandom(), $urandom()});
        kind = $urandom_range(99, 0);
        if (kind < 50) begin
          r.func = FN_ALLOC;
        end else if (kind < 85) begin
          r.func = FN_LOOKUP;
          if (kind < 80) r.byte_offset = 16'($urandom_range(pe * CELL_SZ - 1, 0));
        end else if (kind < 89) begin
          r.func = FN_HEAD;
        end else if (kind < 93) begin
          r.func = FN_LINK;
          lk = forward_link(r.link_cell);
          r.range_first = lk[10:0];
          r.range_last  = lk[21:11];
        end else if (kind < 97) begin
          r.func = 3'($urandom_range(7, FN_SPARE_MIN));
        end else begin
          r.func = FN_INIT;
        end
        send_req(r);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 8'd0;
    in_valid       = 1'b0;
    in_func        = FN_INIT;
    in_byte_offset = 16'd0;
    in_link_cell   = 10'd0;
    in_range_first = 11'd0;
    in_range_last  = 11'd0;
    foreach (link_set[i]) link_set[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_page();
    test_block_sizes();
    test_page_full();
    test_range_end();
    test_walk_limit();
    test_random_free_lists();

    settle();
    repeat (40) @(posedge clk);
    $display("checked %0d replies to %0d requests over block sizes 0..255", replies_got,
             reqs_sent);
    $display("page full seen %0d times, walk limit %0d times, %0d mismatches", full_hits,
             walk_limits, fails);
    if (fails == 0 && due_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== fixed_block_range_allocator_core.f =====
+incdir+rtl
rtl/fbra_pkg.sv
rtl/fbra_div.sv
rtl/fixed_block_range_allocator_core.sv
tb/sv/fixed_block_range_allocator_core_test.sv
